// ===== hdl/foc_current_loop_svm_duty_macros.svh =====
// assertion helpers used by the current loop top
`ifndef FOC_CURRENT_LOOP_SVM_DUTY_MACROS_SVH
`define FOC_CURRENT_LOOP_SVM_DUTY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FOC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FOC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FOC_ASSERT_IMPL(lbl, ante, cons, msg)
`define FOC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/foc_pkg.sv =====
package foc_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_ZERO_A       = 3'd0;
	localparam logic [2:0] CFG_ZERO_B       = 3'd1;
	localparam logic [2:0] CFG_IQ_TARGET    = 3'd2;
	localparam logic [2:0] CFG_PROP_GAIN    = 3'd3;
	localparam logic [2:0] CFG_ANGLE_OFFSET = 3'd4;
	localparam logic [2:0] CFG_BUS_MV       = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic [13:0] DUTY_MIN = 14'd500;
	localparam logic [13:0] DUTY_MAX = 14'd9500;

	// angle folded into one quarter turn
	typedef struct packed {
		logic [14:0] x;
		logic        neg;
	} fold_t;

	function automatic fold_t fold_angle(input logic [15:0] t);
		fold_t r;
		r.x   = t[14] ? 15'(15'd16384 - {1'b0, t[13:0]}) : {1'b0, t[13:0]};
		r.neg = t[15];
		return r;
	endfunction

endpackage

// ===== hdl/foc_sincos.sv =====
module foc_sincos (
	input  logic                clk,
	input  logic                en,
	input  foc_pkg::fold_t      ang,
	output logic signed [16:0]  val
);
	import foc_pkg::*;

	logic [14:0] x_s2, x2_s2, x_s3, x2_s3, x_s4;
	logic        neg_s2, neg_s3, neg_s4;
	logic [13:0] y1_s3;
	logic [14:0] y2_s4;
	logic signed [16:0] val_s5;

	logic [29:0] sq;
	logic [24:0] t1;
	logic [28:0] t2;
	logic [29:0] t3;
	logic signed [16:0] mag;

	// x^2, then the two nested polynomial terms, then the final product
	assign sq  = 30'(ang.x) * 30'(ang.x);
	assign t1  = 25'(x2_s2) * 25'd1160;
	assign t2  = 29'(y1_s3) * 29'(x2_s3);
	assign t3  = 30'(y2_s4) * 30'(x_s4);
	assign mag = signed'({1'b0, t3[29:14]});

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= ang.x;
			x2_s2  <= sq[28:14];
			neg_s2 <= ang.neg;
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			neg_s3 <= neg_s2;
			y1_s3  <= 14'd10512 - 14'(t1[24:14]);
			x_s4   <= x_s3;
			neg_s4 <= neg_s3;
			y2_s4  <= 15'd25736 - 15'(t2[28:14]);
			val_s5 <= neg_s4 ? -mag : mag;
		end
	end

	assign val = val_s5;
endmodule

// ===== hdl/foc_div.sv =====
module foc_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [44:0] num,
	input  logic [29:0]        den,
	input  logic [43:0]        lim,
	output logic [13:0]        duty
);
	import foc_pkg::*;

	typedef struct packed {
		logic lo;
		logic hi;
	} clamp_t;

	logic [43:0] rem_s [15];
	logic [13:0] quo_s [15];
	clamp_t      clp_s [15];
	logic [13:0] duty_q;

	// entry stage: decide the clamps, keep the non-negative numerator
	always_ff @(posedge clk) begin
		if (en) begin
			clp_s[0].lo <= num[44];
			clp_s[0].hi <= !num[44] && (num[43:0] >= lim);
			rem_s[0]    <= num[43:0];
			quo_s[0]    <= '0;
		end
	end

	// one restoring step per stage, msb first
	for (genvar j = 1; j < 15; j++) begin : g_step
		logic [44:0] trial;
		assign trial = 45'(rem_s[j-1]) - (45'(den) << (14 - j));
		always_ff @(posedge clk) begin
			if (en) begin
				clp_s[j] <= clp_s[j-1];
				rem_s[j] <= trial[44] ? rem_s[j-1] : trial[43:0];
				quo_s[j] <= {quo_s[j-1][12:0], !trial[44]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (clp_s[14].lo)
				duty_q <= DUTY_MIN;
			else if (clp_s[14].hi)
				duty_q <= DUTY_MAX;
			else
				duty_q <= quo_s[14] + DUTY_MIN;
		end
	end

	assign duty = duty_q;
endmodule

// ===== hdl/foc_current_loop_svm_duty.sv =====
// channel | dir | handshake              | word
// in      | in  | in_valid / in_stall    | rotor_angle, current_a, current_b
// out     | out | out_valid / out_stall  | duty_u, duty_v, duty_w
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// one word enters per cycle unless in_stall holds it back; results leave in the order their words were taken
// 15 stages of angle, sine, park and voltage maths, then 16 of restoring divide
// the divide by the bus voltage sets the depth: one quotient bit per step stage
// arst_n clears the valid bits and loads the register reset values
// a stalled result freezes the whole pipe, so in_stall follows it at once
`include "foc_current_loop_svm_duty_macros.svh"
module foc_current_loop_svm_duty #(
	parameter int POLE_PAIRS = 7,
	parameter int ANGLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ANGLE_BITS-1:0]         rotor_angle,
	input  logic [11:0]                   current_a,
	input  logic [11:0]                   current_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [13:0]                   duty_u,
	output logic [13:0]                   duty_v,
	output logic [13:0]                   duty_w,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [foc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [foc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import foc_pkg::*;

	localparam int LAT = 31;
	localparam logic signed [48:0] SAT_HI = 49'sd1073741823;
	localparam logic signed [48:0] SAT_LO = -49'sd1073741824;

	// clamp far outside the duty band, keeps the scaling multiply narrow
	function automatic logic signed [30:0] sat31(input logic signed [48:0] d);
		if (d > SAT_HI)
			return 31'(SAT_HI);
		else if (d < SAT_LO)
			return 31'(SAT_LO);
		return 31'(d);
	endfunction

	// configuration, with the derived gain and bus products
	logic [11:0]        zero_a_q, zero_b_q;
	logic signed [20:0] tgt_q;
	logic [25:0]        k_q;
	logic [15:0]        aoff_q;
	logic [15:0]        bus_q;
	logic [28:0]        off4500_q;
	logic [15:0]        bus_eff;

	assign cfg_ready = 1'b1;
	assign bus_eff   = (cfg_data[15:0] < 16'd1000) ? 16'd1000 : cfg_data[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_a_q  <= '0;
			zero_b_q  <= '0;
			tgt_q     <= 21'sd205;
			k_q       <= 26'd384000;
			aoff_q    <= '0;
			bus_q     <= 16'd12000;
			off4500_q <= 29'd54000000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ZERO_A:       zero_a_q <= cfg_data[11:0];
				CFG_ZERO_B:       zero_b_q <= cfg_data[11:0];
				CFG_IQ_TARGET:    tgt_q <= signed'(cfg_data[20:0]);
				CFG_PROP_GAIN:    k_q <= 26'(cfg_data[15:0]) * 26'd1000;
				CFG_ANGLE_OFFSET: aoff_q <= cfg_data[15:0];
				CFG_BUS_MV: begin
					bus_q     <= bus_eff;
					off4500_q <= 29'(bus_eff) * 29'd4500;
				end
				default: ;
			endcase
		end
	end

	// pipe advances unless a result sits stalled at the output
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// s1: electrical angle, folded angles, offset-free currents
	logic [15:0]        ang_sh, theta;
	fold_t              fs_s1, fc_s1;
	logic signed [12:0] ia, ib;
	logic signed [12:0] ia_s1, ia_s2, ia_s3, ia_s4, ia_s5;
	logic signed [14:0] sum_s1;

	assign ang_sh = 16'(rotor_angle) << (16 - ANGLE_BITS);
	assign theta  = 16'(32'(ang_sh) * 32'(POLE_PAIRS)) - aoff_q;
	assign ia     = signed'({1'b0, current_a}) - signed'({1'b0, zero_a_q});
	assign ib     = signed'({1'b0, current_b}) - signed'({1'b0, zero_b_q});

	always_ff @(posedge clk) begin
		if (en) begin
			fs_s1  <= fold_angle(theta);
			fc_s1  <= fold_angle(theta + 16'd16384);
			ia_s1  <= ia;
			sum_s1 <= 15'(ia) + (15'(ib) <<< 1);
		end
	end

	// s2..s5: sine and cosine in q14
	logic signed [16:0] s_s5, c_s5;

	foc_sincos u_sin (.clk(clk), .en(en), .ang(fs_s1), .val(s_s5));
	foc_sincos u_cos (.clk(clk), .en(en), .ang(fc_s1), .val(c_s5));

	// beta current, 1/256 count, alongside the sine stages
	logic signed [29:0] bp_s2;
	logic signed [21:0] beta8_s3, beta8_s4, beta8_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ia_s2    <= ia_s1;
			bp_s2    <= 30'(sum_s1) * 30'sd37837;
			ia_s3    <= ia_s2;
			beta8_s3 <= 22'(bp_s2 >>> 8);
			ia_s4    <= ia_s3;
			beta8_s4 <= beta8_s3;
			ia_s5    <= ia_s4;
			beta8_s5 <= beta8_s4;
		end
	end

	// s6..s9: park to iq, error, proportional gain
	logic signed [36:0] p1_s6, p2_s6;
	logic signed [31:0] cm_s6, cm_s7, cm_s8, cm_s9;
	logic signed [16:0] s_s6, s_s7, s_s8, s_s9;
	logic signed [22:0] iq8_s7, err_s8;
	logic signed [48:0] vqp_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s6  <= -(37'(ia_s5) * 37'(s_s5) * 37'sd256);
			p2_s6  <= 37'(beta8_s5) * 37'(c_s5);
			cm_s6  <= 32'(c_s5) * 32'sd56756;
			s_s6   <= s_s5;
			iq8_s7 <= 23'((p1_s6 + p2_s6) >>> 14);
			cm_s7  <= cm_s6;
			s_s7   <= s_s6;
			err_s8 <= 23'(tgt_q) - iq8_s7;
			cm_s8  <= cm_s7;
			s_s8   <= s_s7;
			vqp_s9 <= 49'(err_s8) * 49'(signed'({1'b0, k_q}));
			cm_s9  <= cm_s8;
			s_s9   <= s_s8;
		end
	end

	// s10..s11: inverse park with vd at zero, split into three phases
	logic signed [32:0] vq;
	logic signed [46:0] va_s10, h;
	logic signed [62:0] hq_s10;
	logic signed [45:0] half;
	logic signed [47:0] v_s11 [3];
	logic signed [47:0] v_s12 [3];

	assign vq   = 33'(vqp_s9 >>> 16);
	assign h    = 47'(hq_s10 >>> 16);
	assign half = 46'((-va_s10) >>> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			va_s10   <= -(47'(vq) * 47'(s_s9));
			hq_s10   <= 63'(vq) * 63'(cm_s9);
			v_s11[0] <= 48'(va_s10);
			v_s11[1] <= 48'(half) + 48'(h);
			v_s11[2] <= 48'(half) - 48'(h);
		end
	end

	// s12: midpoint of max and min
	logic signed [47:0] mx, mn, off_s12;

	always_comb begin
		mx = v_s11[0];
		mn = v_s11[0];
		if (v_s11[1] > mx) mx = v_s11[1];
		if (v_s11[2] > mx) mx = v_s11[2];
		if (v_s11[1] < mn) mn = v_s11[1];
		if (v_s11[2] < mn) mn = v_s11[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s12 <= 48'((49'(mx) + 49'(mn)) >>> 1);
			v_s12   <= v_s11;
		end
	end

	// s13..s15 per phase: inject, scale by 10000, bias by 4500 bus units,
	// then the divide lane
	logic signed [30:0] d_s13   [3];
	logic signed [44:0] np_s14  [3];
	logic signed [44:0] num_s15 [3];
	logic [13:0]        dl      [3];

	for (genvar p = 0; p < 3; p++) begin : g_phase
		always_ff @(posedge clk) begin
			if (en) begin
				d_s13[p]   <= sat31(49'(v_s12[p]) - 49'(off_s12));
				np_s14[p]  <= 45'(d_s13[p]) * 45'sd10000;
				num_s15[p] <= np_s14[p] + signed'(45'({off4500_q, 14'b0}));
			end
		end

		foc_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s15[p]),
			.den ({bus_q, 14'b0}),
			.lim ({off4500_q, 15'b0}),
			.duty(dl[p])
		);
	end

	assign duty_u = dl[0];
	assign duty_v = dl[1];
	assign duty_w = dl[2];

	`FOC_ASSERT_IMPL(a_duty_band, out_valid, (duty_u >= DUTY_MIN && duty_u <= DUTY_MAX && duty_v >= DUTY_MIN && duty_v <= DUTY_MAX && duty_w >= DUTY_MIN && duty_w <= DUTY_MAX), "duty outside saturation band")
	`FOC_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(vld_q), "pipe moved under a stalled result")
	`FOC_ASSERT_NEXT(a_enter, in_valid && !in_stall, vld_q[0], "accepted word missing from first stage")
	`FOC_ASSERT_NEXT(a_bubble, !in_valid && !in_stall, !vld_q[0], "bubble entered as valid word")
endmodule

// ===== dv/foc_duty_checker.sv =====
`timescale 1ns / 1ps
module foc_duty_checker #(
	parameter int POLE_PAIRS = 7,
	parameter int ANGLE_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [ANGLE_BITS-1:0]          rotor_angle,
	input  logic [11:0]                    current_a,
	input  logic [11:0]                    current_b,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [13:0]                    duty_u,
	input  logic [13:0]                    duty_v,
	input  logic [13:0]                    duty_w,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [foc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [foc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             duties_pending
);
	import foc_pkg::*;

	typedef struct packed {
		logic [13:0] u;
		logic [13:0] v;
		logic [13:0] w;
	} duty_set_t;

	duty_set_t duty_q[$];
	logic [11:0] zero_a_r, zero_b_r;
	logic [20:0] target_r;
	logic [15:0] gain_r, offset_r, bus_r;

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic longint quarter_sine(longint x);
		longint x2, y;
		x2 = (x * x) >>> 14;
		y = (1160 * x2) >>> 14;
		y = ((10512 - y) * x2) >>> 14;
		return ((25736 - y) * x) >>> 14;
	endfunction

	function automatic longint sine_q14(logic [15:0] t);
		longint f, v;
		f = t[13:0];
		v = t[14] ? quarter_sine(16384 - f) : quarter_sine(f);
		return t[15] ? -v : v;
	endfunction

	function automatic logic [13:0] scale_duty(longint v, longint bus);
		longint d;
		d = floor_div(v * 10000, bus * 16384) + 5000;
		if (d < 500) d = 500;
		if (d > 9500) d = 9500;
		return d[13:0];
	endfunction

	function automatic duty_set_t predict_duties(logic [ANGLE_BITS-1:0] ang,
			logic [11:0] ca, logic [11:0] cb);
		logic [15:0] theta;
		longint s, c, ia, ib, beta8, iq8, tgt, vq, va, vb, h, half, vu, vv, vw;
		longint mx, mn, off, bus;
		duty_set_t r;
		theta = 16'((32'(ang) << (16 - ANGLE_BITS)) * POLE_PAIRS - 32'(offset_r));
		s = sine_q14(theta);
		c = sine_q14(theta + 16'd16384);
		ia = longint'(ca) - longint'(zero_a_r);
		ib = longint'(cb) - longint'(zero_b_r);
		beta8 = floor_div((ia + 2 * ib) * 37837, 256);
		iq8 = floor_div(-(ia * 256) * s + beta8 * c, 16384);
		tgt = longint'(signed'(target_r));
		vq = floor_div((tgt - iq8) * longint'(gain_r) * 1000, 65536);
		va = -vq * s;
		vb = vq * c;
		h = floor_div(vb * 56756, 65536);
		half = floor_div(-va, 2);
		vu = va; vv = half + h; vw = half - h;
		mx = vu; mn = vu;
		if (vv > mx) mx = vv;
		if (vw > mx) mx = vw;
		if (vv < mn) mn = vv;
		if (vw < mn) mn = vw;
		off = floor_div(mx + mn, 2);
		bus = bus_r < 1000 ? 1000 : bus_r;
		r.u = scale_duty(vu - off, bus);
		r.v = scale_duty(vv - off, bus);
		r.w = scale_duty(vw - off, bus);
		return r;
	endfunction

	assign duties_pending = duty_q.size();

	always @(posedge clk or negedge arst_n) begin
		duty_set_t e;
		if (!arst_n) begin
			zero_a_r = 0; zero_b_r = 0; target_r = 21'd205;
			gain_r = 16'd384; offset_r = 0; bus_r = 16'd12000;
			fail_count = 0;
			duty_q.delete();
		end else begin
			// result side first: a word taken now cannot leave this edge
			if (out_valid && !out_stall) begin
				if (duty_q.size() == 0) begin
					$display("%0t: result with none expected, got %0d %0d %0d",
						$time, duty_u, duty_v, duty_w);
					fail_count++;
				end else begin
					e = duty_q.pop_front();
					if (e.u !== duty_u || e.v !== duty_v || e.w !== duty_w) begin
						$display("%0t: expected %0d %0d %0d, got %0d %0d %0d", $time,
							e.u, e.v, e.w, duty_u, duty_v, duty_w);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				duty_q.push_back(predict_duties(rotor_angle, current_a, current_b));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ZERO_A:       zero_a_r = cfg_data[11:0];
					CFG_ZERO_B:       zero_b_r = cfg_data[11:0];
					CFG_IQ_TARGET:    target_r = cfg_data[20:0];
					CFG_PROP_GAIN:    gain_r = cfg_data[15:0];
					CFG_ANGLE_OFFSET: offset_r = cfg_data[15:0];
					CFG_BUS_MV:       bus_r = cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import foc_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic [11:0] rotor_angle, current_a, current_b;
	logic [13:0] duty_u, duty_v, duty_w;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count, duties_pending;
	int cycle_count = 0;
	bit long_hold; // receiver hold-off request

	foc_current_loop_svm_duty dut (.*);
	foc_duty_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit: several times the slowest expected run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stall process, one long hold on request
	initial begin
		int n;
		bit held;
		held = 0;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold && !held) begin
				out_stall <= 1;
				repeat (200) @(posedge clk);
				held = 1;
			end
			n = gap_len();
			if (n == 0) begin
				out_stall <= 0;
				@(posedge clk);
			end else begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	task automatic send_word(logic [11:0] ang, logic [11:0] ca, logic [11:0] cb);
		in_valid <= 1;
		rotor_angle <= ang; current_a <= ca; current_b <= cb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_gapped(logic [11:0] ang, logic [11:0] ca, logic [11:0] cb);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		send_word(ang, ca, cb);
	endtask

	// waits for every result, then pipe latency before touching registers
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (duties_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [11:0] za, logic [11:0] zb, logic [20:0] tg,
			logic [15:0] pg, logic [15:0] ao, logic [15:0] bus);
		write_reg(CFG_ZERO_A, 21'(za));
		write_reg(CFG_ZERO_B, 21'(zb));
		write_reg(CFG_IQ_TARGET, tg);
		write_reg(CFG_PROP_GAIN, 21'(pg));
		write_reg(CFG_ANGLE_OFFSET, 21'(ao));
		write_reg(CFG_BUS_MV, 21'(bus));
	endtask

	task automatic random_words(int n);
		int i;
		for (i = 0; i < n; i++)
			send_gapped(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
				12'($urandom_range(0, 4095)));
	endtask

	initial begin
		int ph;
		arst_n = 0;
		in_valid = 0; rotor_angle = 0; current_a = 0; current_b = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		long_hold = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed words at reset settings: field extremes and quadrant edges
		send_word(0, 0, 0);
		send_word(4095, 4095, 4095);
		send_word(0, 4095, 0);
		send_word(0, 0, 4095);
		send_word(585, 2048, 2048);
		send_word(1170, 1000, 3000);
		send_word(2048, 4095, 0);
		send_word(2925, 0, 4095);
		send_word(12'hAAA, 12'h555, 12'hAAA);
		send_word(12'h555, 12'hAAA, 12'h555);
		drain();

		// bus below range, extreme gain and target, unknown register index
		set_regs(12'd2048, 12'd2048, 21'h0FFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		write_reg(3'd6, 21'h1FFFFF);
		write_reg(3'd7, 21'h000001);
		send_word(0, 2048, 2048);
		send_word(4095, 0, 4095);
		send_word(1000, 4095, 0);
		send_word(3000, 1234, 3210);
		drain();
		set_regs(12'd4095, 12'd4095, 21'h100000, 16'd0, 16'd0, 16'd999);
		send_word(0, 0, 0);
		send_word(2000, 4095, 4095);
		drain();
		set_regs(12'd0, 12'd0, 21'd0, 16'd1, 16'd32768, 16'hFFFF);
		send_word(1, 4095, 0);
		send_word(4094, 0, 4095);
		drain();

		// random phases with random settings, extremes mixed in
		for (ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				set_regs(12'd2048, 12'd2048, 21'd205, 16'd384, 16'd0, 16'd1000);
			else if (ph == 1)
				set_regs(12'd2048, 12'd2048, 21'h1FFFFF, 16'd2000, 16'd12345, 16'd65535);
			else
				set_regs(12'($urandom_range(1800, 2300)), 12'($urandom_range(0, 4095)),
					21'($urandom), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			if (ph == 3) begin
				// fill the pipe against a held receiver
				long_hold = 1;
				repeat (60) send_word(12'($urandom), 12'($urandom), 12'($urandom));
			end
			random_words(200);
			drain();
		end

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/foc_pkg.sv
hdl/foc_sincos.sv
hdl/foc_div.sv
hdl/foc_current_loop_svm_duty.sv
dv/foc_duty_checker.sv
dv/tb.sv
